@@ hw/rtl/lrpe_pkg.sv @@
// ============================================================================
// LR parse engine package
// Shared item types, command and result codes, and sequencer states.
// ============================================================================
package lrpe_pkg;

    localparam int RED_W = 6;   // reduction counter, holds up to 63

    typedef struct packed {
        logic [1:0] mode;
        logic [5:0] state_index;
        logic [3:0] symbol;
        logic [1:0] entry_kind;
        logic [5:0] entry_number;
        logic [3:0] rhs_length;
    } t_cmd;

    typedef struct packed {
        logic [1:0] event_res;
        logic [2:0] error_kind;
        logic [5:0] number;
        logic [5:0] state_after;
        logic [6:0] stack_level;
        logic       last;
    } t_res;

    // command modes
    localparam logic [1:0] MODE_ACTION = 2'd0;
    localparam logic [1:0] MODE_GOTO   = 2'd1;
    localparam logic [1:0] MODE_RULE   = 2'd2;
    localparam logic [1:0] MODE_TOKEN  = 2'd3;

    // action entry kinds
    localparam logic [1:0] KIND_EMPTY  = 2'd0;
    localparam logic [1:0] KIND_SHIFT  = 2'd1;
    localparam logic [1:0] KIND_REDUCE = 2'd2;
    localparam logic [1:0] KIND_ACCEPT = 2'd3;

    // result events
    localparam logic [1:0] EV_SHIFT  = 2'd0;
    localparam logic [1:0] EV_REDUCE = 2'd1;
    localparam logic [1:0] EV_ACCEPT = 2'd2;
    localparam logic [1:0] EV_ERROR  = 2'd3;

    // error kinds
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_ACTION = 3'd1;
    localparam logic [2:0] ERR_NO_GOTO   = 3'd2;
    localparam logic [2:0] ERR_STACK     = 3'd3;
    localparam logic [2:0] ERR_REDUCE    = 3'd4;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ACTION,
        S_RULE,
        S_UNDER,
        S_GOTO
    } t_state;

endpackage

@@ hw/rtl/lrpe_ram.sv @@
// ============================================================================
// LR parse engine RAM
// Simple dual-port RAM: one write port, one read port, registered read data.
// ============================================================================
module lrpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ hw/rtl/lr_table_driven_parse_engine_top.sv @@
// ============================================================================
// LR table-driven parse engine
// Shift-reduce sequencer over ACTION, GOTO, rule and state-stack RAMs.
// ============================================================================
// Usage:
//   Commands enter on i_cmd, taken at a clock edge with start high and busy
//   low. Modes 0..2 write an ACTION, GOTO or rule entry in the accept cycle
//   and produce no result; busy stays low. Mode 3 runs one token: every
//   reduction gives one result beat, then one final shift, accept or error
//   beat with last set. Each beat is on o_res for exactly one cycle with
//   o_valid high; the receiver cannot stall, so nothing waits on it.
//   Token sequence: the ACTION lookup gives the final beat; each reduction
//   adds the ACTION, rule, stack and GOTO reads, each one RAM read latency in
//   sequence. busy is high over the whole token and drops in the cycle of the
//   last beat.
//   After reset the ACTION and GOTO RAMs are swept to empty, one entry a
//   cycle, over max(STATE_COUNT*TERMINAL_COUNT, STATE_COUNT*NONTERMINAL_COUNT)
//   entries (1024 at the defaults) with busy high. The stack then holds the
//   single state 0, as it does again after any accept or error.
// ============================================================================
module lr_table_driven_parse_engine_top #(
    parameter int STATE_COUNT       = 64,
    parameter int TERMINAL_COUNT    = 16,
    parameter int NONTERMINAL_COUNT = 16,
    parameter int RULE_COUNT        = 64,
    parameter int STACK_DEPTH       = 64,
    parameter int MAX_REDUCTIONS    = 63
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  lrpe_pkg::t_cmd i_cmd,
    output logic           o_valid,
    output lrpe_pkg::t_res o_res
);

    import lrpe_pkg::*;

    localparam int ACT_DEPTH = STATE_COUNT * TERMINAL_COUNT;
    localparam int GTO_DEPTH = STATE_COUNT * NONTERMINAL_COUNT;
    localparam int CLR_DEPTH = (ACT_DEPTH > GTO_DEPTH) ? ACT_DEPTH : GTO_DEPTH;
    localparam int AAW       = $clog2(ACT_DEPTH);
    localparam int GAW       = $clog2(GTO_DEPTH);
    localparam int CLW       = $clog2(CLR_DEPTH);
    localparam int RAW       = $clog2(RULE_COUNT);
    localparam int SAW       = $clog2(STACK_DEPTH);
    localparam int CW        = $clog2(STACK_DEPTH + 1);

    t_state                r_state, n_state;
    logic [CLW-1:0]        r_clr, n_clr;
    logic [5:0]            r_top, n_top;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_newcount, n_newcount;
    logic [3:0]            r_sym, n_sym;
    logic [3:0]            r_left, n_left;
    logic [5:0]            r_num, n_num;
    logic [RED_W-1:0]      r_red, n_red;
    logic                  r_miss, n_miss;
    logic                  r_valid, n_valid;
    t_res                  r_res, n_res;

    // RAM ports
    logic                  act_we, gto_we, rul_we, stk_we;
    logic [AAW-1:0]        act_waddr, act_raddr;
    logic [GAW-1:0]        gto_waddr, gto_raddr;
    logic [RAW-1:0]        rul_waddr, rul_raddr;
    logic [SAW-1:0]        stk_waddr, stk_raddr;
    logic [7:0]            act_wdata, act_rdata;
    logic [6:0]            gto_wdata, gto_rdata;
    logic [7:0]            rul_wdata, rul_rdata;
    logic [5:0]            stk_wdata, stk_rdata;

    // address helpers
    logic [5:0]            a_state;
    logic [3:0]            a_sym;
    logic [31:0]           a_idx, ld_aidx, ld_gidx, g_idx, ld_ridx, rd_ridx;
    logic                  a_hit;
    logic [5:0]            g_state;
    logic                  g_hit;
    logic [7:0]            entry;
    logic [7:0]            rule;
    logic [6:0]            gval;
    logic [CW-1:0]         nc, nc_m1, push_lvl;
    logic                  accept;

    lrpe_ram #(.WIDTH(8), .DEPTH(ACT_DEPTH)) u_action (
        .i_clk   (i_clk),
        .i_we    (act_we),
        .i_waddr (act_waddr),
        .i_wdata (act_wdata),
        .i_raddr (act_raddr),
        .o_rdata (act_rdata)
    );

    lrpe_ram #(.WIDTH(7), .DEPTH(GTO_DEPTH)) u_goto (
        .i_clk   (i_clk),
        .i_we    (gto_we),
        .i_waddr (gto_waddr),
        .i_wdata (gto_wdata),
        .i_raddr (gto_raddr),
        .o_rdata (gto_rdata)
    );

    lrpe_ram #(.WIDTH(8), .DEPTH(RULE_COUNT)) u_rule (
        .i_clk   (i_clk),
        .i_we    (rul_we),
        .i_waddr (rul_waddr),
        .i_wdata (rul_wdata),
        .i_raddr (rul_raddr),
        .o_rdata (rul_rdata)
    );

    lrpe_ram #(.WIDTH(6), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // load addresses straight from the command beat
    assign ld_aidx = 32'(i_cmd.state_index) * 32'(TERMINAL_COUNT) + 32'(i_cmd.symbol);
    assign ld_gidx = 32'(i_cmd.state_index) * 32'(NONTERMINAL_COUNT) + 32'(i_cmd.symbol);
    assign ld_ridx = 32'(i_cmd.entry_number);

    // ACTION lookup: top state from the stack on a new token, goto target after a reduce
    assign a_state   = (r_state == S_GOTO) ? gto_rdata[5:0] : r_top;
    assign a_sym     = (r_state == S_GOTO) ? r_sym : i_cmd.symbol;
    assign a_idx     = 32'(a_state) * 32'(TERMINAL_COUNT) + 32'(a_sym);
    assign a_hit     = (32'(a_state) < 32'(STATE_COUNT)) && (32'(a_sym) < 32'(TERMINAL_COUNT));
    assign act_raddr = a_idx[AAW-1:0];

    // GOTO lookup from the uncovered state
    assign g_state   = stk_rdata;
    assign g_idx     = 32'(g_state) * 32'(NONTERMINAL_COUNT) + 32'(r_left);
    assign g_hit     = (32'(g_state) < 32'(STATE_COUNT))
                       && (32'(r_left) < 32'(NONTERMINAL_COUNT));
    assign gto_raddr = g_idx[GAW-1:0];

    assign entry = r_miss ? 8'd0 : act_rdata;
    assign rule  = r_miss ? 8'd0 : rul_rdata;
    assign gval  = r_miss ? 7'd0 : gto_rdata;

    assign rd_ridx   = 32'(entry[5:0]);
    assign rul_raddr = rd_ridx[RAW-1:0];

    assign nc        = r_count - CW'(rule[3:0]);
    assign nc_m1     = nc - CW'(1);
    assign stk_raddr = nc_m1[SAW-1:0];
    assign push_lvl  = r_count + CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_top   <= '0;
            r_count <= CW'(1);
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_top   <= n_top;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_newcount <= n_newcount;
        r_sym      <= n_sym;
        r_left     <= n_left;
        r_num      <= n_num;
        r_red      <= n_red;
        r_miss     <= n_miss;
        r_res      <= n_res;
    end

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_top      = r_top;
        n_count    = r_count;
        n_newcount = r_newcount;
        n_sym      = r_sym;
        n_left     = r_left;
        n_num      = r_num;
        n_red      = r_red;
        n_miss     = r_miss;
        n_valid    = 1'b0;
        n_res      = r_res;

        act_we    = 1'b0;
        act_waddr = ld_aidx[AAW-1:0];
        act_wdata = {i_cmd.entry_kind, i_cmd.entry_number};
        gto_we    = 1'b0;
        gto_waddr = ld_gidx[GAW-1:0];
        gto_wdata = (i_cmd.entry_kind != KIND_EMPTY) ? {1'b1, i_cmd.entry_number} : 7'd0;
        rul_we    = 1'b0;
        rul_waddr = ld_ridx[RAW-1:0];
        rul_wdata = {i_cmd.symbol, i_cmd.rhs_length};
        stk_we    = 1'b0;
        stk_waddr = r_count[SAW-1:0];
        stk_wdata = entry[5:0];

        case (r_state)
            S_CLEAR: begin
                act_waddr = r_clr[AAW-1:0];
                act_wdata = 8'd0;
                act_we    = (32'(r_clr) < 32'(ACT_DEPTH));
                gto_waddr = r_clr[GAW-1:0];
                gto_wdata = 7'd0;
                gto_we    = (32'(r_clr) < 32'(GTO_DEPTH));
                // bottom of stack holds state 0 for good
                stk_waddr = '0;
                stk_wdata = 6'd0;
                stk_we    = (r_clr == '0);
                n_clr     = r_clr + CLW'(1);
                if (32'(r_clr) == 32'(CLR_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd.mode)
                        MODE_ACTION: begin
                            act_we = (32'(i_cmd.state_index) < 32'(STATE_COUNT))
                                     && (32'(i_cmd.symbol) < 32'(TERMINAL_COUNT));
                        end
                        MODE_GOTO: begin
                            gto_we = (32'(i_cmd.state_index) < 32'(STATE_COUNT))
                                     && (32'(i_cmd.symbol) < 32'(NONTERMINAL_COUNT));
                        end
                        MODE_RULE: begin
                            rul_we = (32'(i_cmd.entry_number) < 32'(RULE_COUNT));
                        end
                        MODE_TOKEN: begin
                            n_sym   = i_cmd.symbol;
                            n_red   = '0;
                            n_miss  = !a_hit;
                            n_state = S_ACTION;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ACTION: begin
                n_valid          = 1'b1;
                n_res.number     = 6'd0;
                n_res.state_after = 6'd0;
                n_res.stack_level = 7'd1;
                n_res.last       = 1'b1;
                n_res.error_kind = ERR_NONE;
                n_state          = S_IDLE;
                case (entry[7:6])
                    KIND_EMPTY: begin
                        n_res.event_res  = EV_ERROR;
                        n_res.error_kind = ERR_NO_ACTION;
                        n_top            = 6'd0;
                        n_count          = CW'(1);
                    end
                    KIND_ACCEPT: begin
                        n_res.event_res = EV_ACCEPT;
                        n_top           = 6'd0;
                        n_count         = CW'(1);
                    end
                    KIND_SHIFT: begin
                        if (32'(r_count) >= 32'(STACK_DEPTH)) begin
                            n_res.event_res  = EV_ERROR;
                            n_res.error_kind = ERR_STACK;
                            n_top            = 6'd0;
                            n_count          = CW'(1);
                        end else begin
                            stk_we            = 1'b1;
                            n_top             = entry[5:0];
                            n_count           = push_lvl;
                            n_res.event_res   = EV_SHIFT;
                            n_res.number      = entry[5:0];
                            n_res.state_after = entry[5:0];
                            n_res.stack_level = 7'(push_lvl);
                        end
                    end
                    default: begin
                        // reduce: fetch the rule, no beat yet (error beat at the reduction limit)
                        if (32'(r_red) >= 32'(MAX_REDUCTIONS)) begin
                            n_res.event_res  = EV_ERROR;
                            n_res.error_kind = ERR_REDUCE;
                            n_top            = 6'd0;
                            n_count          = CW'(1);
                        end else begin
                            n_valid = 1'b0;
                            n_num   = entry[5:0];
                            n_miss  = !(32'(entry[5:0]) < 32'(RULE_COUNT));
                            n_state = S_RULE;
                        end
                    end
                endcase
            end
            S_RULE: begin
                if (32'(rule[3:0]) >= 32'(r_count)) begin
                    n_valid   = 1'b1;
                    n_res     = '{EV_ERROR, ERR_STACK, 6'd0, 6'd0, 7'd1, 1'b1};
                    n_top     = 6'd0;
                    n_count   = CW'(1);
                    n_state   = S_IDLE;
                end else begin
                    // pop and read the uncovered state
                    n_left     = rule[7:4];
                    n_newcount = nc;
                    n_state    = S_UNDER;
                end
            end
            S_UNDER: begin
                n_miss  = !g_hit;
                n_state = S_GOTO;
            end
            S_GOTO: begin
                n_valid = 1'b1;
                if (!gval[6]) begin
                    n_res   = '{EV_ERROR, ERR_NO_GOTO, 6'd0, 6'd0, 7'd1, 1'b1};
                    n_top   = 6'd0;
                    n_count = CW'(1);
                    n_state = S_IDLE;
                end else if (32'(r_newcount) >= 32'(STACK_DEPTH)) begin
                    n_res   = '{EV_ERROR, ERR_STACK, 6'd0, 6'd0, 7'd1, 1'b1};
                    n_top   = 6'd0;
                    n_count = CW'(1);
                    n_state = S_IDLE;
                end else begin
                    stk_we    = 1'b1;
                    stk_waddr = r_newcount[SAW-1:0];
                    stk_wdata = gval[5:0];
                    n_top     = gval[5:0];
                    n_count   = r_newcount + CW'(1);
                    n_res     = '{EV_REDUCE, ERR_NONE, r_num, gval[5:0],
                                  7'(r_newcount + CW'(1)), 1'b0};
                    n_red     = r_red + RED_W'(1);
                    // look up the next action from the goto target
                    n_miss    = !a_hit;
                    n_state   = S_ACTION;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ tb/tb.sv @@
// ============================================================================
// tb: LR table-driven parse engine testbench
// Loads ACTION, GOTO and rule entries and feeds tokens through the start/busy
// handshake. A local copy of the tables and stack predicts each beat but the
// pinned final beats of directed steps; beats are compared field by field in
// arrival order. Directed steps lead, then random grammars and stack bursts.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lrpe_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int STK_DEPTH   = 64;
    localparam int RED_MAX     = 63;
    localparam int N_DIR       = 25;
    localparam int RAND_ITEMS  = 350;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 16;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    t_cmd i_cmd   = '0;
    logic o_valid;
    t_res o_res;

    // pinned final beat travels with the command, so it is sampled like one
    logic pin_en   = 1'b0;
    t_res pin_beat = '0;

    // parser copy: ACTION {kind, number}, GOTO {present, target}, rule {left, len}
    logic [7:0] act_tab  [1024];
    logic [6:0] goto_tab [1024];
    logic [7:0] rule_tab [64];
    logic [5:0] stk      [STK_DEPTH];
    int         stk_cnt = 1;
    t_res       pending [$];

    bit rule_known [64];
    bit steady   = 1'b0;
    int n_bad    = 0;
    int n_items  = 0;
    int n_cycles = 0;

    typedef struct {
        logic [1:0] mode;
        logic [5:0] st;
        logic [3:0] sym;
        logic [1:0] kind;
        logic [5:0] num;
        logic [3:0] len;
        bit         pin;
        logic [1:0] ev;
        logic [2:0] err;
        logic [5:0] rnum;
        logic [5:0] rstate;
        logic [6:0] lvl;
    } t_step;

    // mode, state, symbol, kind, number, length | pin, event, error, number, state, level
    t_step steps [N_DIR] = '{
        '{MODE_TOKEN,   0,  0, 0,            0,  0, 1, EV_ERROR,  ERR_NO_ACTION, 0,  0,  1},
        '{MODE_TOKEN,  63, 15, 3,           63, 15, 1, EV_ERROR,  ERR_NO_ACTION, 0,  0,  1},
        '{MODE_RULE,    0,  1, 0,            0,  1, 0, 0,         0,             0,  0,  0},
        '{MODE_RULE,   63, 15, 3,           63,  0, 0, 0,         0,             0,  0,  0},
        '{MODE_RULE,    0,  2, 0,            1, 15, 0, 0,         0,             0,  0,  0},
        '{MODE_ACTION,  0,  0, KIND_SHIFT,   5,  0, 0, 0,         0,             0,  0,  0},
        '{MODE_ACTION,  5, 15, KIND_REDUCE,  0,  0, 0, 0,         0,             0,  0,  0},
        '{MODE_GOTO,    0,  1, 1,           63,  0, 0, 0,         0,             0,  0,  0},
        '{MODE_ACTION, 63, 15, KIND_ACCEPT, 42, 15, 0, 0,         0,             0,  0,  0},
        '{MODE_TOKEN,   0,  0, 0,            0,  0, 1, EV_SHIFT,  ERR_NONE,      5,  5,  2},
        '{MODE_TOKEN,   0, 15, 0,            0,  0, 1, EV_ACCEPT, ERR_NONE,      0,  0,  1},
        '{MODE_ACTION,  0,  2, KIND_REDUCE,  1,  0, 0, 0,         0,             0,  0,  0},
        '{MODE_TOKEN,   0,  2, 0,            0,  0, 1, EV_ERROR,  ERR_STACK,     0,  0,  1},
        '{MODE_ACTION,  0,  3, KIND_REDUCE, 63,  0, 0, 0,         0,             0,  0,  0},
        '{MODE_TOKEN,   0,  3, 0,            0,  0, 1, EV_ERROR,  ERR_NO_GOTO,   0,  0,  1},
        '{MODE_GOTO,    0, 15, 3,            0,  0, 0, 0,         0,             0,  0,  0},
        '{MODE_TOKEN,   0,  3, 0,            0,  0, 1, EV_ERROR,  ERR_REDUCE,    0,  0,  1},
        '{MODE_GOTO,    0, 15, 0,           63,  0, 0, 0,         0,             0,  0,  0},
        '{MODE_TOKEN,   0,  3, 0,            0,  0, 1, EV_ERROR,  ERR_NO_GOTO,   0,  0,  1},
        '{MODE_ACTION,  0,  0, KIND_EMPTY,  63,  0, 0, 0,         0,             0,  0,  0},
        '{MODE_TOKEN,   0,  0, 0,            0,  0, 1, EV_ERROR,  ERR_NO_ACTION, 0,  0,  1},
        '{MODE_ACTION,  0, 14, KIND_SHIFT,  63,  0, 0, 0,         0,             0,  0,  0},
        '{MODE_ACTION, 63, 14, KIND_SHIFT,  63,  0, 0, 0,         0,             0,  0,  0},
        '{MODE_TOKEN,   0, 14, 0,            0,  0, 1, EV_SHIFT,  ERR_NONE,     63, 63,  2},
        '{MODE_TOKEN,   0, 14, 0,            0,  0, 1, EV_SHIFT,  ERR_NONE,     63, 63,  3}
    };

    lr_table_driven_parse_engine_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic logic [1:0] rnd2();
        return 2'($urandom);
    endfunction

    function automatic logic [3:0] rnd4();
        return 4'($urandom);
    endfunction

    function automatic logic [5:0] rnd6();
        return 6'($urandom);
    endfunction

    function automatic t_cmd cmd_of(logic [1:0] m, logic [5:0] s, logic [3:0] y,
                                    logic [1:0] k, logic [5:0] n, logic [3:0] l);
        t_cmd c;
        c.mode         = m;
        c.state_index  = s;
        c.symbol       = y;
        c.entry_kind   = k;
        c.entry_number = n;
        c.rhs_length   = l;
        return c;
    endfunction

    // reduce entries may only name rules already loaded
    function automatic logic [5:0] known_rule();
        logic [5:0] n;
        do n = rnd6(); while (!rule_known[n]);
        return n;
    endfunction

    function automatic void cmp_field(string name, logic [6:0] want, logic [6:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_bad++;
        end
    endfunction

    // Apply one accepted command and queue the beats it must produce.
    task automatic run_parser(input t_cmd c, input bit pin, input t_res pinned);
        t_res       beat;
        logic [7:0] ent;
        logic [7:0] rule;
        logic [6:0] g;
        logic [2:0] fault;
        int         red;
        bit         done;
        case (c.mode)
            MODE_ACTION: act_tab[{c.state_index, c.symbol}] = {c.entry_kind, c.entry_number};
            MODE_GOTO: goto_tab[{c.state_index, c.symbol}] =
                (c.entry_kind != KIND_EMPTY) ? {1'b1, c.entry_number} : 7'd0;
            MODE_RULE: rule_tab[c.entry_number] = {c.symbol, c.rhs_length};
            default: begin
                red  = 0;
                done = 1'b0;
                while (!done) begin
                    ent   = act_tab[{stk[stk_cnt - 1], c.symbol}];
                    beat  = '0;
                    fault = ERR_NONE;
                    done  = 1'b1;
                    case (ent[7:6])
                        KIND_EMPTY: fault = ERR_NO_ACTION;
                        KIND_ACCEPT: begin
                            stk_cnt          = 1;
                            beat.event_res   = EV_ACCEPT;
                            beat.stack_level = 7'd1;
                        end
                        KIND_SHIFT: begin
                            if (stk_cnt >= STK_DEPTH) begin
                                fault = ERR_STACK;
                            end else begin
                                stk[stk_cnt]     = ent[5:0];
                                stk_cnt++;
                                beat.event_res   = EV_SHIFT;
                                beat.number      = ent[5:0];
                                beat.state_after = ent[5:0];
                                beat.stack_level = 7'(stk_cnt);
                            end
                        end
                        default: begin
                            rule = rule_tab[ent[5:0]];
                            if (red >= RED_MAX) begin
                                fault = ERR_REDUCE;
                            end else if (int'(rule[3:0]) >= stk_cnt) begin
                                fault = ERR_STACK;
                            end else begin
                                stk_cnt -= int'(rule[3:0]);
                                g = goto_tab[{stk[stk_cnt - 1], rule[7:4]}];
                                if (!g[6]) begin
                                    fault = ERR_NO_GOTO;
                                end else if (stk_cnt >= STK_DEPTH) begin
                                    fault = ERR_STACK;
                                end else begin
                                    stk[stk_cnt]     = g[5:0];
                                    stk_cnt++;
                                    beat.event_res   = EV_REDUCE;
                                    beat.number      = ent[5:0];
                                    beat.state_after = g[5:0];
                                    beat.stack_level = 7'(stk_cnt);
                                    red++;
                                    done = 1'b0;
                                end
                            end
                        end
                    endcase
                    if (fault != ERR_NONE) begin
                        stk_cnt          = 1;
                        beat.event_res   = EV_ERROR;
                        beat.error_kind  = fault;
                        beat.stack_level = 7'd1;
                    end
                    beat.last = done;
                    if (done && pin) beat = pinned;
                    pending.insert(pending.size(), beat);
                end
            end
        endcase
    endtask

    // Present one command and hold it until the engine takes it.
    task automatic send(input t_cmd c, input bit pin = 1'b0, input t_res pres = '0);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start    <= 1'b1;
        i_cmd    <= c;
        pin_en   <= pin;
        pin_beat <= pres;
        if (c.mode == MODE_RULE) rule_known[c.entry_number] = 1'b1;
        n_items++;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic send_token(input logic [3:0] sym);
        send(cmd_of(MODE_TOKEN, rnd6(), sym, rnd2(), rnd6(), rnd4()));
    endtask

    always @(posedge i_clk) begin : mon
        t_res want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (pending.size() == 0) begin
                    $error("result beat with none expected: event_res %0d", o_res.event_res);
                    n_bad++;
                end else begin
                    want = pending.pop_front();
                    cmp_field("event_res", 7'(want.event_res), 7'(o_res.event_res));
                    cmp_field("error_kind", 7'(want.error_kind), 7'(o_res.error_kind));
                    cmp_field("number", 7'(want.number), 7'(o_res.number));
                    cmp_field("state_after", 7'(want.state_after), 7'(o_res.state_after));
                    cmp_field("stack_level", want.stack_level, o_res.stack_level);
                    cmp_field("last", 7'(want.last), 7'(o_res.last));
                end
            end
            if (start && !busy) run_parser(i_cmd, pin_en, pin_beat);
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin : stim
        logic [5:0] sts   [8];
        logic [3:0] terms [4];
        logic [3:0] lefts [3];
        logic [5:0] rules [6];
        int         nr;
        int         n_tok;
        int         roll;
        logic [1:0] k;
        logic [5:0] num;
        logic [5:0] b;
        logic [5:0] rz;
        logic [3:0] t;
        logic [3:0] u;
        logic [3:0] lf;
        t_cmd       c;
        t_res       r;
        foreach (act_tab[i]) act_tab[i] = '0;
        foreach (goto_tab[i]) goto_tab[i] = '0;
        foreach (rule_tab[i]) rule_tab[i] = '0;
        foreach (stk[i]) stk[i] = '0;
        foreach (rule_known[i]) rule_known[i] = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (steps[i]) begin
            c = cmd_of(steps[i].mode, steps[i].st, steps[i].sym,
                       steps[i].kind, steps[i].num, steps[i].len);
            r.event_res   = steps[i].ev;
            r.error_kind  = steps[i].err;
            r.number      = steps[i].rnum;
            r.state_after = steps[i].rstate;
            r.stack_level = steps[i].lvl;
            r.last        = 1'b1;
            send(c, steps[i].pin, r);
        end

        while (n_items < N_DIR + RAND_ITEMS) begin
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0) begin
                // self-looping shifts drive the stack to or near its bound, then an
                // empty rule that loops on its own goto state
                b  = 6'($urandom_range(1, 63));
                t  = rnd4();
                u  = t + 4'($urandom_range(1, 15));
                rz = rnd6();
                lf = rnd4();
                send(cmd_of(MODE_RULE, rnd6(), lf, rnd2(), rz, 4'd0));
                send(cmd_of(MODE_ACTION, 6'd0, t, KIND_SHIFT, b, rnd4()));
                send(cmd_of(MODE_ACTION, b, t, KIND_SHIFT, b, rnd4()));
                send(cmd_of(MODE_GOTO, b, lf, 2'($urandom_range(1, 3)), b, rnd4()));
                send(cmd_of(MODE_ACTION, b, u, KIND_REDUCE, rz, rnd4()));
                n_tok = $urandom_range(58, 66);
                repeat (n_tok) send_token(t);
                send_token(u);
            end else begin
                // small random grammar rooted at state 0
                sts[0] = 6'd0;
                for (int i = 1; i < 8; i++) sts[i] = 6'($urandom_range(1, 63));
                foreach (terms[i]) terms[i] = rnd4();
                foreach (lefts[i]) lefts[i] = rnd4();
                nr = $urandom_range(2, 6);
                for (int i = 0; i < nr; i++) begin
                    rules[i] = rnd6();
                    num = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 2))
                                                     : 6'($urandom_range(3, 15));
                    send(cmd_of(MODE_RULE, rnd6(), lefts[$urandom_range(0, 2)], rnd2(),
                                rules[i], num[3:0]));
                end
                foreach (sts[i]) begin
                    foreach (terms[j]) begin
                        if ($urandom_range(0, 1) == 0) continue;
                        roll = $urandom_range(0, 9);
                        if (roll < 4) begin
                            k   = KIND_SHIFT;
                            num = sts[$urandom_range(0, 7)];
                        end else if (roll < 7) begin
                            k   = KIND_REDUCE;
                            num = rules[$urandom_range(0, nr - 1)];
                        end else begin
                            k   = (roll < 8) ? KIND_ACCEPT : KIND_EMPTY;
                            num = rnd6();
                        end
                        send(cmd_of(MODE_ACTION, sts[i], terms[j], k, num, rnd4()));
                    end
                end
                foreach (sts[i]) begin
                    foreach (lefts[j]) begin
                        if ($urandom_range(0, 1) == 0) continue;
                        send(cmd_of(MODE_GOTO, sts[i], lefts[j], rnd2(),
                                    sts[$urandom_range(0, 7)], rnd4()));
                    end
                end
                n_tok = $urandom_range(30, 60);
                repeat (n_tok) begin
                    if ($urandom_range(0, 9) == 0) begin
                        // stray command anywhere in the tables
                        c = cmd_of(rnd2(), rnd6(), rnd4(), rnd2(), rnd6(), rnd4());
                        if (c.mode == MODE_ACTION && c.entry_kind == KIND_REDUCE)
                            c.entry_number = known_rule();
                        send(c);
                    end else if ($urandom_range(0, 6) == 0) begin
                        send_token(rnd4());
                    end else begin
                        send_token(terms[$urandom_range(0, 3)]);
                    end
                end
            end
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (pending.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_bad == 0 && pending.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
